FILE: src/ests_pkg.sv
`default_nettype none

package ests_pkg;

    // operation codes of an input transaction
    localparam logic [2:0] OP_READ       = 3'd0;
    localparam logic [2:0] OP_WRITE      = 3'd1;
    localparam logic [2:0] OP_ERASE      = 3'd2;
    localparam logic [2:0] OP_QUERY      = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_FRAME_DONE = 3'd5;

    // spi command bytes
    localparam logic [7:0] OPC_WAKE   = 8'hAB;
    localparam logic [7:0] OPC_WREN   = 8'h06;
    localparam logic [7:0] OPC_READ   = 8'h03;
    localparam logic [7:0] OPC_WRITE  = 8'h02;
    localparam logic [7:0] OPC_ERASE  = 8'hC7;
    localparam logic [7:0] OPC_STATUS = 8'h05;
    localparam logic [7:0] OPC_SLEEP  = 8'hB9;

    // register indexes of the configuration port
    localparam logic REG_FIRST_CS  = 1'b0;
    localparam logic REG_SECOND_CS = 1'b1;

    typedef enum logic [2:0] {
        PH_QUEUED = 3'd0,
        PH_WAKE   = 3'd1,
        PH_WREN   = 3'd2,
        PH_ACTION = 3'd3,
        PH_POLL   = 3'd4,
        PH_SLEEP  = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_START,
        ST_SCAN,
        ST_FIND,
        ST_FRAME,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FREE,
        CMD_START,
        CMD_SCAN,
        CMD_FIND,
        CMD_FRAME
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
        logic busy;
        logic restart;
    } status_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [17:0] address;
        logic [7:0]  length;
        logic [15:0] buffer_ref;
        logic [7:0]  lookup_id;
        logic [7:0]  status_byte;
    } req_t;

    typedef struct packed {
        logic        result_code;
        logic [7:0]  assigned_id;
        logic        done_flag;
        logic        frame_start;
        logic [7:0]  frame_chip;
        logic [7:0]  frame_opcode;
        logic [16:0] frame_address;
        logic [8:0]  frame_tx_bytes;
        logic [7:0]  frame_rx_bytes;
        logic [15:0] frame_buffer_ref;
        logic        frame_uses_buffer;
    } rsp_t;

endpackage

`default_nettype wire

FILE: src/ests_req_if.sv
`default_nettype none

interface ests_req_if;
    logic              valid;
    logic              ready;
    ests_pkg::req_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/ests_rsp_if.sv
`default_nettype none

interface ests_rsp_if;
    logic              valid;
    logic              ready;
    ests_pkg::rsp_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/ests_ctrl.sv
`default_nettype none

module ests_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [2:0]        in_op,
    output ests_pkg::cmd_t         cmd,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  ests_pkg::status_t      status
);

    ests_pkg::state_t state_reg;
    ests_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ests_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ests_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == ests_pkg::OP_READ || in_op == ests_pkg::OP_WRITE ||
                        in_op == ests_pkg::OP_ERASE)
                        state_next = ests_pkg::ST_FREE;
                    else if (in_op == ests_pkg::OP_QUERY || in_op == ests_pkg::OP_CLEAR)
                        state_next = ests_pkg::ST_FIND;
                    else if (in_op == ests_pkg::OP_FRAME_DONE)
                        state_next = ests_pkg::ST_FRAME;
                    else
                        state_next = ests_pkg::ST_RESP;
                end
            end
            ests_pkg::ST_FREE:
            begin
                if (status.hit)
                    state_next = ests_pkg::ST_START;
                else if (status.last)
                    state_next = ests_pkg::ST_RESP;
            end
            ests_pkg::ST_START:
            begin
                state_next = status.busy ? ests_pkg::ST_RESP : ests_pkg::ST_SCAN;
            end
            ests_pkg::ST_SCAN, ests_pkg::ST_FIND:
            begin
                if (status.hit || status.last)
                    state_next = ests_pkg::ST_RESP;
            end
            ests_pkg::ST_FRAME:
            begin
                state_next = status.restart ? ests_pkg::ST_START : ests_pkg::ST_RESP;
            end
            ests_pkg::ST_RESP:
            begin
                if (out_ready)
                    state_next = ests_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ests_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = ests_pkg::CMD_NONE;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ests_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd = ests_pkg::CMD_LOAD;
            end
            ests_pkg::ST_FREE:  cmd = ests_pkg::CMD_FREE;
            ests_pkg::ST_START: cmd = ests_pkg::CMD_START;
            ests_pkg::ST_SCAN:  cmd = ests_pkg::CMD_SCAN;
            ests_pkg::ST_FIND:  cmd = ests_pkg::CMD_FIND;
            ests_pkg::ST_FRAME: cmd = ests_pkg::CMD_FRAME;
            ests_pkg::ST_RESP:  out_valid = 1'b1;
            default:            cmd = ests_pkg::CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/ests_datapath.sv
`default_nettype none

module ests_datapath #(
    parameter int QUEUE_SLOTS      = 5,
    parameter int CHIP_TOP_ADDRESS = 131071
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  ests_pkg::cmd_t         cmd,
    input  ests_pkg::req_t         in_data,
    input  wire logic [7:0]        first_cs,
    input  wire logic [7:0]        second_cs,
    output ests_pkg::status_t      status,
    output ests_pkg::rsp_t         result
);

    localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);
    localparam logic [24:0]      TOP_ADDR = 25'(CHIP_TOP_ADDRESS);

    // slot bookkeeping, initialised by reset
    logic [7:0]          tag_reg   [QUEUE_SLOTS];
    ests_pkg::phase_t    phase_reg [QUEUE_SLOTS];
    logic [IDX_W-1:0]    head_reg;
    logic [7:0]          next_tag_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    cnt_reg;

    // slot payload, undefined until written
    logic [7:0]          chip_reg   [QUEUE_SLOTS];
    logic [16:0]         addr_reg   [QUEUE_SLOTS];
    logic [7:0]          len_reg    [QUEUE_SLOTS];
    logic                wr_reg     [QUEUE_SLOTS];
    logic                er_reg     [QUEUE_SLOTS];
    logic [15:0]         buf_reg    [QUEUE_SLOTS];

    ests_pkg::req_t      req_reg;
    ests_pkg::rsp_t      rsp_reg;

    logic [7:0]          tag_p;
    ests_pkg::phase_t    phase_p;
    logic [7:0]          chip_p;
    logic                wr_p;
    logic                er_p;
    logic [IDX_W-1:0]    ptr_inc;
    logic                is_erase_req;
    logic                is_write_req;
    logic                upper_half;
    logic [24:0]         addr_ext;
    logic [16:0]         local_addr;
    logic [7:0]          new_chip;
    logic [7:0]          tag_inc;

    // frame launch decided at the pointed slot
    logic                emit;
    logic [7:0]          e_opcode;
    logic [16:0]         e_addr;
    logic [8:0]          e_tx;
    logic [7:0]          e_rx;
    logic                e_buf;
    logic                e_second;
    ests_pkg::phase_t    ph_next;

    assign tag_p   = tag_reg[ptr_reg];
    assign phase_p = phase_reg[ptr_reg];
    assign chip_p  = chip_reg[ptr_reg];
    assign wr_p    = wr_reg[ptr_reg];
    assign er_p    = er_reg[ptr_reg];
    assign ptr_inc = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;

    assign is_erase_req = (req_reg.operation == ests_pkg::OP_ERASE);
    assign is_write_req = (req_reg.operation == ests_pkg::OP_WRITE);
    assign addr_ext     = {7'd0, req_reg.address};
    assign upper_half   = !is_erase_req && (addr_ext > TOP_ADDR);
    assign local_addr   = is_erase_req ? 17'd0 :
                          upper_half   ? 17'(addr_ext - TOP_ADDR - 25'd1) :
                                         req_reg.address[16:0];
    assign new_chip     = upper_half ? second_cs : first_cs;
    assign tag_inc      = (next_tag_reg == 8'hFF) ? 8'd1 : next_tag_reg + 8'd1;

    always_comb
    begin
        status.hit     = 1'b0;
        status.last    = (cnt_reg == LAST_IDX);
        status.busy    = (phase_p != ests_pkg::PH_QUEUED) && (phase_p != ests_pkg::PH_DONE);
        status.restart = (phase_p == ests_pkg::PH_SLEEP) && !(er_p && chip_p == first_cs);
        case (cmd)
            ests_pkg::CMD_FREE: status.hit = (tag_p == 8'd0);
            ests_pkg::CMD_SCAN: status.hit = (tag_p != 8'd0) &&
                                             (phase_p == ests_pkg::PH_QUEUED);
            ests_pkg::CMD_FIND: status.hit = (tag_p == req_reg.lookup_id);
            default:            status.hit = 1'b0;
        endcase
        if (cmd != ests_pkg::CMD_FRAME)
            status.restart = 1'b0;
    end

    always_comb
    begin
        emit     = 1'b0;
        e_opcode = 8'd0;
        e_addr   = 17'd0;
        e_tx     = 9'd0;
        e_rx     = 8'd0;
        e_buf    = 1'b0;
        e_second = 1'b0;
        ph_next  = phase_p;
        if (cmd == ests_pkg::CMD_SCAN && status.hit)
        begin
            emit     = 1'b1;
            e_opcode = ests_pkg::OPC_WAKE;
            e_tx     = 9'd4;
            e_rx     = 8'd1;
            ph_next  = ests_pkg::PH_WAKE;
        end
        else if (cmd == ests_pkg::CMD_FRAME)
        begin
            unique case (phase_p)
                ests_pkg::PH_WAKE, ests_pkg::PH_WREN:
                begin
                    emit = 1'b1;
                    if (phase_p == ests_pkg::PH_WAKE && (wr_p || er_p))
                    begin
                        e_opcode = ests_pkg::OPC_WREN;
                        e_tx     = 9'd1;
                        ph_next  = ests_pkg::PH_WREN;
                    end
                    else if (er_p)
                    begin
                        e_opcode = ests_pkg::OPC_ERASE;
                        e_tx     = 9'd1;
                        ph_next  = ests_pkg::PH_ACTION;
                    end
                    else if (wr_p)
                    begin
                        e_opcode = ests_pkg::OPC_WRITE;
                        e_addr   = addr_reg[ptr_reg];
                        e_tx     = {1'b0, len_reg[ptr_reg]} + 9'd4;
                        e_buf    = 1'b1;
                        ph_next  = ests_pkg::PH_ACTION;
                    end
                    else
                    begin
                        e_opcode = ests_pkg::OPC_READ;
                        e_addr   = addr_reg[ptr_reg];
                        e_tx     = 9'd4;
                        e_rx     = len_reg[ptr_reg];
                        e_buf    = 1'b1;
                        ph_next  = ests_pkg::PH_ACTION;
                    end
                end
                ests_pkg::PH_ACTION, ests_pkg::PH_POLL:
                begin
                    emit = 1'b1;
                    // polling goes on while the busy bit is set
                    if ((phase_p == ests_pkg::PH_ACTION && (wr_p || er_p)) ||
                        (phase_p == ests_pkg::PH_POLL && req_reg.status_byte[0]))
                    begin
                        e_opcode = ests_pkg::OPC_STATUS;
                        e_tx     = 9'd1;
                        e_rx     = 8'd1;
                        ph_next  = ests_pkg::PH_POLL;
                    end
                    else
                    begin
                        e_opcode = ests_pkg::OPC_SLEEP;
                        e_tx     = 9'd1;
                        ph_next  = ests_pkg::PH_SLEEP;
                    end
                end
                ests_pkg::PH_SLEEP:
                begin
                    if (status.restart)
                    begin
                        ph_next = ests_pkg::PH_DONE;
                    end
                    else
                    begin
                        // erase moves on to the second chip
                        emit     = 1'b1;
                        e_second = 1'b1;
                        e_opcode = ests_pkg::OPC_WAKE;
                        e_tx     = 9'd4;
                        e_rx     = 8'd1;
                        ph_next  = ests_pkg::PH_WAKE;
                    end
                end
                default:
                begin
                    ph_next = phase_p;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                tag_reg[i]   <= 8'd0;
                phase_reg[i] <= ests_pkg::PH_QUEUED;
            end
            head_reg     <= '0;
            next_tag_reg <= 8'd1;
            ptr_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            case (cmd)
                ests_pkg::CMD_LOAD:
                begin
                    cnt_reg <= '0;
                    if (in_data.operation == ests_pkg::OP_QUERY ||
                        in_data.operation == ests_pkg::OP_CLEAR)
                        ptr_reg <= '0;
                    else
                        ptr_reg <= head_reg;
                end
                ests_pkg::CMD_FREE:
                begin
                    if (status.hit)
                    begin
                        tag_reg[ptr_reg]   <= next_tag_reg;
                        phase_reg[ptr_reg] <= ests_pkg::PH_QUEUED;
                        next_tag_reg       <= tag_inc;
                        ptr_reg            <= head_reg;
                        cnt_reg            <= '0;
                    end
                    else if (!status.last)
                    begin
                        ptr_reg <= ptr_inc;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ests_pkg::CMD_START:
                begin
                    cnt_reg <= '0;
                end
                ests_pkg::CMD_SCAN:
                begin
                    if (status.hit)
                    begin
                        head_reg           <= ptr_reg;
                        phase_reg[ptr_reg] <= ph_next;
                    end
                    else
                    begin
                        ptr_reg <= ptr_inc;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ests_pkg::CMD_FIND:
                begin
                    if (status.hit)
                    begin
                        if (req_reg.operation == ests_pkg::OP_CLEAR &&
                            phase_p == ests_pkg::PH_DONE)
                            tag_reg[ptr_reg] <= 8'd0;
                    end
                    else
                    begin
                        ptr_reg <= ptr_inc;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ests_pkg::CMD_FRAME:
                begin
                    phase_reg[ptr_reg] <= ph_next;
                    if (status.restart)
                    begin
                        head_reg <= ptr_inc;
                        ptr_reg  <= ptr_inc;
                    end
                end
                default:
                begin
                    ptr_reg <= ptr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == ests_pkg::CMD_LOAD)
        begin
            req_reg <= in_data;
            rsp_reg <= '0;
        end
        if (cmd == ests_pkg::CMD_FREE)
        begin
            if (status.hit)
            begin
                chip_reg[ptr_reg]    <= is_erase_req ? first_cs : new_chip;
                addr_reg[ptr_reg]    <= local_addr;
                len_reg[ptr_reg]     <= is_erase_req ? 8'd0 : req_reg.length;
                buf_reg[ptr_reg]     <= is_erase_req ? 16'd0 : req_reg.buffer_ref;
                wr_reg[ptr_reg]      <= is_write_req;
                er_reg[ptr_reg]      <= is_erase_req;
                rsp_reg.assigned_id  <= next_tag_reg;
            end
            else if (status.last)
            begin
                rsp_reg.result_code <= 1'b1;
            end
        end
        if (cmd == ests_pkg::CMD_FIND && (status.hit || status.last))
        begin
            if (req_reg.operation == ests_pkg::OP_QUERY)
                rsp_reg.done_flag <= status.hit && (phase_p == ests_pkg::PH_DONE);
            else
                rsp_reg.result_code <= !(status.hit && (phase_p == ests_pkg::PH_DONE));
        end
        if (e_second)
            chip_reg[ptr_reg] <= second_cs;
        if (emit)
        begin
            rsp_reg.frame_start       <= 1'b1;
            rsp_reg.frame_chip        <= e_second ? second_cs : chip_p;
            rsp_reg.frame_opcode      <= e_opcode;
            rsp_reg.frame_address     <= e_addr;
            rsp_reg.frame_tx_bytes    <= e_tx;
            rsp_reg.frame_rx_bytes    <= e_rx;
            rsp_reg.frame_buffer_ref  <= e_buf ? buf_reg[ptr_reg] : 16'd0;
            rsp_reg.frame_uses_buffer <= e_buf;
        end
    end

    assign result = rsp_reg;

endmodule

`default_nettype wire

FILE: src/spi_eeprom_transaction_sequencer.sv
`default_nettype none

// channel | dir | handshake     | transaction
// req     | in  | valid / ready | request, query, clear or frame completion
// rsp     | out | valid / ready | result code, id, done flag and frame descriptor
// apb     | in  | psel/penable  | chip select codes at byte addresses 0 and 4
//
// one transaction runs from its accept through to the taking of its result
// the length is set by the slot scans, one slot per cycle through a single pointer
// a request that finds the queue full is refused after a scan of every slot
// reset is asynchronous and active low; the queue comes up empty with ids from 1
// req is refused while a result is waiting on rsp; rsp holds until taken

module spi_eeprom_transaction_sequencer #(
    parameter int QUEUE_SLOTS      = 5,
    parameter int CHIP_TOP_ADDRESS = 131071
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    ests_req_if.sink           req,
    ests_rsp_if.source         rsp
);

    // configuration registers
    logic [7:0] first_cs_reg;
    logic [7:0] second_cs_reg;
    logic       cfg_write;

    ests_pkg::cmd_t    cmd;
    ests_pkg::status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // register index sits in address bit 2, byte lanes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cs_reg  <= 8'd0;
            second_cs_reg <= 8'd1;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ests_pkg::REG_FIRST_CS)
                first_cs_reg <= pwdata[7:0];
            else
                second_cs_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == ests_pkg::REG_SECOND_CS)
            prdata = {24'd0, second_cs_reg};
        else
            prdata = {24'd0, first_cs_reg};
    end

    // sequencing of scans and frame steps
    ests_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_op     (req.data.operation),
        .cmd       (cmd),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status)
    );

    // slot queue, id counter and result register
    ests_datapath #(
        .QUEUE_SLOTS      (QUEUE_SLOTS),
        .CHIP_TOP_ADDRESS (CHIP_TOP_ADDRESS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (req.data),
        .first_cs  (first_cs_reg),
        .second_cs (second_cs_reg),
        .status    (status),
        .result    (rsp.data)
    );

endmodule

`default_nettype wire

FILE: src/ests_checker.sv
`default_nettype none

module ests_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic            req_ready,
    input  wire logic            rsp_valid,
    input  wire logic            rsp_ready,
    input  ests_pkg::rsp_t       rsp_data
);

    // a waiting result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // one transaction at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("new transaction taken while one is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while result pending");

    // no descriptor fields without a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.frame_start |->
            rsp_data.frame_opcode == 8'd0 && rsp_data.frame_tx_bytes == 9'd0)
        else $error("frame fields set without frame start");

    // a refusal neither assigns an id nor launches a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.result_code |->
            rsp_data.assigned_id == 8'd0 && !rsp_data.frame_start)
        else $error("refused transaction has side results");

endmodule

bind spi_eeprom_transaction_sequencer ests_checker u_ests_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
